FILE: rtl/biquad_lowpass_with_warmup_top_macros.svh
// Assertion helpers shared by the filter RTL.
// Both expect a signal named clk, and BIQ_ASSERT also rst_n, in the module that uses them.
`ifndef BIQUAD_LOWPASS_WITH_WARMUP_TOP_MACROS_SVH
`define BIQUAD_LOWPASS_WITH_WARMUP_TOP_MACROS_SVH

`ifndef SYNTH

// checked only outside reset
`define BIQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BIQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BIQ_ASSERT(lbl, prop, msg)
`define BIQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/biq_pkg.sv
package biq_pkg;

    localparam int DEF_SAMPLE_WIDTH = 32;
    localparam int DEF_COEF_WIDTH   = 24;

    // Q3.20 coefficients
    localparam int FRAC_BITS = 20;
    localparam int COEF_ONE  = 1 << FRAC_BITS;

    localparam int WARMUP_WIDTH = 8;
    localparam logic [WARMUP_WIDTH-1:0] WARMUP_RESET = 8'd100;
    localparam logic [WARMUP_WIDTH-1:0] WARMUP_MAX   = '1;

    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_B0    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_B1    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_B2    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A1    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A2    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WARMUP_LEN = 3'd5;

endpackage

FILE: rtl/biquad_lowpass_with_warmup_top.sv
// Biquad low-pass filter (direct form I) with warm-up pass-through.
//
// Input stream s_axis: one signed Q16.16 sample per transaction.
// Output stream m_axis: the filtered sample in tdata, tuser high when the
// sample was passed through unfiltered during warm-up.
// Config port: cfg_we / cfg_index / cfg_data write b0, b1, b2, a1, a2 (Q3.20)
// and warmup_len; write only while the filter is idle.
//
// Path: an accepted sample is held in the input register, then makes one pass
// through five multipliers and a saturating adder into the output register.
// Throughput: one sample per cycle while m_axis_tready is high. The output
// history feeds back within that single pass, so each sample sees the
// previous result at full rate.
// Stall: when m_axis_tready is low the result holds, the input register keeps
// one more sample, and s_axis_tready drops once both are full.
// Reset: coefficients return to b0 = 1.0 and all others 0, warmup_len to 100,
// delay lines and warm-up count to zero, both streams empty.
`include "biquad_lowpass_with_warmup_top_macros.svh"

module biquad_lowpass_with_warmup_top
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int TDATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    parameter int CFG_WIDTH    = (COEF_WIDTH > WARMUP_WIDTH) ? COEF_WIDTH : WARMUP_WIDTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [TDATA_WIDTH-1:0]      s_axis_tdata,   // sample_in
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [TDATA_WIDTH-1:0]      m_axis_tdata,   // sample_out
    output logic                        m_axis_tuser,   // warming
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]        cfg_data
);

    logic signed [COEF_WIDTH-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic [WARMUP_WIDTH-1:0]      warmup_len;

    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_reg;
    logic                           out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]        out_sample_reg;
    logic                           out_warming_reg;

    logic                           adv;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic                           warming;

    biq_cfg #(
        .COEF_WIDTH (COEF_WIDTH),
        .DATA_WIDTH (CFG_WIDTH)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coef_b0    (coef_b0),
        .coef_b1    (coef_b1),
        .coef_b2    (coef_b2),
        .coef_a1    (coef_a1),
        .coef_a2    (coef_a2),
        .warmup_len (warmup_len)
    );

    biq_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .sample     (in_sample_reg),
        .coef_b0    (coef_b0),
        .coef_b1    (coef_b1),
        .coef_b2    (coef_b2),
        .coef_a1    (coef_a1),
        .coef_a2    (coef_a2),
        .warmup_len (warmup_len),
        .y          (y),
        .warming    (warming)
    );

    // the held sample moves on when the output register is free or draining
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_sample_reg <= s_axis_tdata[SAMPLE_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_sample_reg  <= y;
            out_warming_reg <= warming;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_WIDTH'(out_sample_reg);
    assign m_axis_tuser  = out_warming_reg;

    `BIQ_ASSERT(a_adv_fills_out, adv |=> out_valid_reg, "processed sample did not reach the output register")
    `BIQ_ASSERT(a_in_hold, in_valid_reg && !adv |=> in_valid_reg && $stable(in_sample_reg), "waiting sample lost or changed")
    `BIQ_ASSERT(a_accept_fills_in, s_axis_tvalid && s_axis_tready |=> in_valid_reg, "accepted transaction not held")
    `BIQ_ASSERT_ALWAYS(a_ready_when_empty, !in_valid_reg |-> s_axis_tready, "input stalled while empty")

endmodule

FILE: rtl/biq_cfg.sv
module biq_cfg
    import biq_pkg::*;
#(
    parameter int COEF_WIDTH = DEF_COEF_WIDTH,
    parameter int DATA_WIDTH = (DEF_COEF_WIDTH > WARMUP_WIDTH) ? DEF_COEF_WIDTH : WARMUP_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [DATA_WIDTH-1:0]         cfg_data,
    output logic signed [COEF_WIDTH-1:0]  coef_b0,
    output logic signed [COEF_WIDTH-1:0]  coef_b1,
    output logic signed [COEF_WIDTH-1:0]  coef_b2,
    output logic signed [COEF_WIDTH-1:0]  coef_a1,
    output logic signed [COEF_WIDTH-1:0]  coef_a2,
    output logic [WARMUP_WIDTH-1:0]       warmup_len
);

    logic signed [COEF_WIDTH-1:0] coef_b0_reg;
    logic signed [COEF_WIDTH-1:0] coef_b1_reg;
    logic signed [COEF_WIDTH-1:0] coef_b2_reg;
    logic signed [COEF_WIDTH-1:0] coef_a1_reg;
    logic signed [COEF_WIDTH-1:0] coef_a2_reg;
    logic [WARMUP_WIDTH-1:0]      warmup_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg    <= COEF_WIDTH'(COEF_ONE);
            coef_b1_reg    <= '0;
            coef_b2_reg    <= '0;
            coef_a1_reg    <= '0;
            coef_a2_reg    <= '0;
            warmup_len_reg <= WARMUP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_B0:    coef_b0_reg    <= cfg_data[COEF_WIDTH-1:0];
                REG_COEF_B1:    coef_b1_reg    <= cfg_data[COEF_WIDTH-1:0];
                REG_COEF_B2:    coef_b2_reg    <= cfg_data[COEF_WIDTH-1:0];
                REG_COEF_A1:    coef_a1_reg    <= cfg_data[COEF_WIDTH-1:0];
                REG_COEF_A2:    coef_a2_reg    <= cfg_data[COEF_WIDTH-1:0];
                REG_WARMUP_LEN: warmup_len_reg <= cfg_data[WARMUP_WIDTH-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign coef_b0    = coef_b0_reg;
    assign coef_b1    = coef_b1_reg;
    assign coef_b2    = coef_b2_reg;
    assign coef_a1    = coef_a1_reg;
    assign coef_a2    = coef_a2_reg;
    assign warmup_len = warmup_len_reg;

endmodule

FILE: rtl/biq_core.sv
`include "biquad_lowpass_with_warmup_top_macros.svh"

module biq_core
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample,
    input  logic signed [COEF_WIDTH-1:0]    coef_b0,
    input  logic signed [COEF_WIDTH-1:0]    coef_b1,
    input  logic signed [COEF_WIDTH-1:0]    coef_b2,
    input  logic signed [COEF_WIDTH-1:0]    coef_a1,
    input  logic signed [COEF_WIDTH-1:0]    coef_a2,
    input  logic [WARMUP_WIDTH-1:0]         warmup_len,
    output logic signed [SAMPLE_WIDTH-1:0]  y,
    output logic                            warming
);

    localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int TW = PW - FRAC_BITS;
    // headroom for five terms, and at least one bit above the sample range
    localparam int AW = ((TW > SAMPLE_WIDTH) ? TW : SAMPLE_WIDTH) + 3;

    logic signed [SAMPLE_WIDTH-1:0] in_prev1_reg, in_prev2_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_prev1_reg, out_prev2_reg;
    logic [WARMUP_WIDTH-1:0]        warmup_count_reg, warmup_count_next;

    logic signed [PW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [TW-1:0] t_b0, t_b1, t_b2, t_a1, t_a2;
    logic signed [AW-1:0] acc;
    logic signed [SAMPLE_WIDTH-1:0] y_filt;

    assign p_b0 = PW'(sample)        * PW'(coef_b0);
    assign p_b1 = PW'(in_prev1_reg)  * PW'(coef_b1);
    assign p_b2 = PW'(in_prev2_reg)  * PW'(coef_b2);
    assign p_a1 = PW'(out_prev1_reg) * PW'(coef_a1);
    assign p_a2 = PW'(out_prev2_reg) * PW'(coef_a2);

    // dropping the fraction bits floors toward minus infinity
    assign t_b0 = p_b0[PW-1:FRAC_BITS];
    assign t_b1 = p_b1[PW-1:FRAC_BITS];
    assign t_b2 = p_b2[PW-1:FRAC_BITS];
    assign t_a1 = p_a1[PW-1:FRAC_BITS];
    assign t_a2 = p_a2[PW-1:FRAC_BITS];

    assign acc = AW'(t_b0) + AW'(t_b1) + AW'(t_b2) - AW'(t_a1) - AW'(t_a2);

    always_comb
    begin
        if (!acc[AW-1] && (|acc[AW-2:SAMPLE_WIDTH-1]))
            y_filt = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        else if (acc[AW-1] && !(&acc[AW-2:SAMPLE_WIDTH-1]))
            y_filt = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            y_filt = acc[SAMPLE_WIDTH-1:0];
    end

    assign warming = (warmup_count_reg < warmup_len);
    assign y       = warming ? sample : y_filt;

    always_comb
    begin
        warmup_count_next = warmup_count_reg;
        if (warming && (warmup_count_reg != WARMUP_MAX))
            warmup_count_next = warmup_count_reg + 1'b1;
    end

    // delay lines shift on every processed sample, warm-up or not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_prev1_reg     <= '0;
            in_prev2_reg     <= '0;
            out_prev1_reg    <= '0;
            out_prev2_reg    <= '0;
            warmup_count_reg <= '0;
        end
        else if (adv)
        begin
            in_prev2_reg     <= in_prev1_reg;
            in_prev1_reg     <= sample;
            out_prev2_reg    <= out_prev1_reg;
            out_prev1_reg    <= y;
            warmup_count_reg <= warmup_count_next;
        end
    end

    `BIQ_ASSERT(a_in_line_hold, !adv |=> $stable(in_prev1_reg) && $stable(in_prev2_reg), "input delay line moved without a sample")
    `BIQ_ASSERT(a_out_line_hold, !adv |=> $stable(out_prev1_reg) && $stable(warmup_count_reg), "output history moved without a sample")
    `BIQ_ASSERT(a_in_line_load, adv |=> in_prev1_reg == $past(sample), "input delay line missed a sample")

endmodule
